/* rtl/aabb_affine_transform_top_defines.svh */
// Assertion macros for the AABB affine transform block
`ifndef AABB_AFFINE_TRANSFORM_TOP_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define AAT_ASSERT_SAME(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define AAT_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define AAT_ASSERT_SAME(label, ck, rn, ante, cons)
`define AAT_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

/* rtl/aat_pkg.sv */
// Types and constants for the AABB affine transform block
package aat_pkg;

    localparam int CoordWidth   = 24;
    localparam int CoefWidth    = 16;
    localparam int FracBits     = 12;
    localparam int NumAxes      = 3;
    localparam int ProdWidth    = CoordWidth + CoefWidth;
    localparam int SumWidth     = ProdWidth + 2;
    localparam int QuotWidth    = SumWidth - FracBits;
    localparam int CfgDataWidth = NumAxes * CoefWidth;
    localparam int CfgIdxWidth  = 3;

    localparam logic [CfgIdxWidth-1:0] CfgRowX   = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CfgRowY   = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CfgRowZ   = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CfgShiftX = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CfgShiftY = 3'd4;
    localparam logic [CfgIdxWidth-1:0] CfgShiftZ = 3'd5;

    localparam logic [CfgDataWidth-1:0] RowXReset = CfgDataWidth'(1) << FracBits;
    localparam logic [CfgDataWidth-1:0] RowYReset =
        CfgDataWidth'(1) << (FracBits + CoefWidth);
    localparam logic [CfgDataWidth-1:0] RowZReset =
        CfgDataWidth'(1) << (FracBits + 2 * CoefWidth);

    typedef struct packed {
        logic signed [CoordWidth-1:0] x_min;
        logic signed [CoordWidth-1:0] x_max;
        logic signed [CoordWidth-1:0] y_min;
        logic signed [CoordWidth-1:0] y_max;
        logic signed [CoordWidth-1:0] z_min;
        logic signed [CoordWidth-1:0] z_max;
    } in_box_t;

    typedef struct packed {
        logic signed [CoordWidth-1:0] out_x_min;
        logic signed [CoordWidth-1:0] out_x_max;
        logic signed [CoordWidth-1:0] out_y_min;
        logic signed [CoordWidth-1:0] out_y_max;
        logic signed [CoordWidth-1:0] out_z_min;
        logic signed [CoordWidth-1:0] out_z_max;
    } out_box_t;

endpackage

/* rtl/aabb_affine_transform_top.sv */
// Top level: pipelined affine transform of an axis-aligned box
//
//  channel  signals                          role
//  in       in_valid, in_ready, in_data      box bounds, Q12.12
//  out      out_valid, out_ready, out_data   enclosing box of mapped corners
//  cfg      cfg_write, cfg_index, cfg_data   matrix rows and translation
//
// Four register stages: products, per-term min/max, sums, round and clamp.
// One box per cycle is sustained while the output is not stalled, set by the
// eighteen 16x24 multipliers in the first stage.
// Reset clears the valid bits and loads the identity transform.
// A stall at the output holds each full stage with no empty stage after it; others still fill.
`include "aabb_affine_transform_top_defines.svh"

module aabb_affine_transform_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  aat_pkg::in_box_t                      in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output aat_pkg::out_box_t                     out_data,
    input  logic                                  cfg_write,
    input  logic [aat_pkg::CfgIdxWidth-1:0]       cfg_index,
    input  logic [aat_pkg::CfgDataWidth-1:0]      cfg_data
);
    import aat_pkg::*;

    logic [CfgDataWidth-1:0]       row_reg   [NumAxes];
    logic signed [CoordWidth-1:0]  shift_reg [NumAxes];

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    logic signed [CoordWidth-1:0] bnd_a [NumAxes];
    logic signed [CoordWidth-1:0] bnd_b [NumAxes];
    logic signed [CoefWidth-1:0]  coef  [NumAxes][NumAxes];

    logic signed [ProdWidth-1:0] prod_a_next [NumAxes][NumAxes];
    logic signed [ProdWidth-1:0] prod_b_next [NumAxes][NumAxes];
    logic signed [ProdWidth-1:0] prod_a_reg  [NumAxes][NumAxes];
    logic signed [ProdWidth-1:0] prod_b_reg  [NumAxes][NumAxes];

    logic signed [ProdWidth-1:0] term_lo_next [NumAxes][NumAxes];
    logic signed [ProdWidth-1:0] term_hi_next [NumAxes][NumAxes];
    logic signed [ProdWidth-1:0] term_lo_reg  [NumAxes][NumAxes];
    logic signed [ProdWidth-1:0] term_hi_reg  [NumAxes][NumAxes];

    logic signed [SumWidth-1:0] sum_lo_next [NumAxes];
    logic signed [SumWidth-1:0] sum_hi_next [NumAxes];
    logic signed [SumWidth-1:0] sum_lo_reg  [NumAxes];
    logic signed [SumWidth-1:0] sum_hi_reg  [NumAxes];

    logic signed [CoordWidth-1:0] res_lo [NumAxes];
    logic signed [CoordWidth-1:0] res_hi [NumAxes];
    out_box_t out_next;
    out_box_t out_reg;
    logic     term_order_ok;
    logic     out_order_ok;

    function automatic logic signed [CoordWidth-1:0] round_clamp
        (input logic signed [SumWidth-1:0] s);
        logic signed [QuotWidth-1:0] q;
        logic signed [QuotWidth-1:0] hi_lim;
        logic signed [QuotWidth-1:0] lo_lim;
        logic signed [CoordWidth-1:0] r;
        q      = QuotWidth'(s >>> FracBits);
        hi_lim = QuotWidth'({1'b0, {(CoordWidth-1){1'b1}}});
        lo_lim = ~hi_lim;
        if (q > hi_lim)
        begin
            r = {1'b0, {(CoordWidth-1){1'b1}}};
        end
        else if (q < lo_lim)
        begin
            r = {1'b1, {(CoordWidth-1){1'b0}}};
        end
        else
        begin
            r = CoordWidth'(q);
        end
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0]   <= RowXReset;
            row_reg[1]   <= RowYReset;
            row_reg[2]   <= RowZReset;
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CfgRowX:   row_reg[0]   <= cfg_data;
                CfgRowY:   row_reg[1]   <= cfg_data;
                CfgRowZ:   row_reg[2]   <= cfg_data;
                CfgShiftX: shift_reg[0] <= cfg_data[CoordWidth-1:0];
                CfgShiftY: shift_reg[1] <= cfg_data[CoordWidth-1:0];
                CfgShiftZ: shift_reg[2] <= cfg_data[CoordWidth-1:0];
                default:   ;
            endcase
        end
    end

    // pipeline flow control
    always_comb
    begin
        rdy4     = !v4_reg || out_ready;
        rdy3     = !v3_reg || rdy4;
        rdy2     = !v2_reg || rdy3;
        rdy1     = !v1_reg || rdy2;
        in_ready = rdy1;
        v1_next  = rdy1 ? in_valid : v1_reg;
        v2_next  = rdy2 ? v1_reg : v2_reg;
        v3_next  = rdy3 ? v2_reg : v3_reg;
        v4_next  = rdy4 ? v3_reg : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // stage 1: coefficient times each bound
    always_comb
    begin
        bnd_a[0] = in_data.x_min;
        bnd_b[0] = in_data.x_max;
        bnd_a[1] = in_data.y_min;
        bnd_b[1] = in_data.y_max;
        bnd_a[2] = in_data.z_min;
        bnd_b[2] = in_data.z_max;
        for (int a = 0; a < NumAxes; a++)
        begin
            for (int k = 0; k < NumAxes; k++)
            begin
                coef[a][k]        = $signed(row_reg[a][k*CoefWidth +: CoefWidth]);
                prod_a_next[a][k] = ProdWidth'(coef[a][k]) * ProdWidth'(bnd_a[k]);
                prod_b_next[a][k] = ProdWidth'(coef[a][k]) * ProdWidth'(bnd_b[k]);
            end
        end
    end

    // stage 2: per-term extremes
    always_comb
    begin
        for (int a = 0; a < NumAxes; a++)
        begin
            for (int k = 0; k < NumAxes; k++)
            begin
                if (prod_a_reg[a][k] < prod_b_reg[a][k])
                begin
                    term_lo_next[a][k] = prod_a_reg[a][k];
                    term_hi_next[a][k] = prod_b_reg[a][k];
                end
                else
                begin
                    term_lo_next[a][k] = prod_b_reg[a][k];
                    term_hi_next[a][k] = prod_a_reg[a][k];
                end
            end
        end
    end

    // stage 3: sum terms, translation and rounding offset
    always_comb
    begin
        for (int a = 0; a < NumAxes; a++)
        begin
            sum_lo_next[a] = SumWidth'(term_lo_reg[a][0]) + SumWidth'(term_lo_reg[a][1])
                           + SumWidth'(term_lo_reg[a][2])
                           + (SumWidth'(shift_reg[a]) <<< FracBits)
                           + (SumWidth'(1) << (FracBits - 1));
            sum_hi_next[a] = SumWidth'(term_hi_reg[a][0]) + SumWidth'(term_hi_reg[a][1])
                           + SumWidth'(term_hi_reg[a][2])
                           + (SumWidth'(shift_reg[a]) <<< FracBits)
                           + (SumWidth'(1) << (FracBits - 1));
        end
    end

    // stage 4: drop fraction bits and saturate
    always_comb
    begin
        for (int a = 0; a < NumAxes; a++)
        begin
            res_lo[a] = round_clamp(sum_lo_reg[a]);
            res_hi[a] = round_clamp(sum_hi_reg[a]);
        end
        out_next.out_x_min = res_lo[0];
        out_next.out_x_max = res_hi[0];
        out_next.out_y_min = res_lo[1];
        out_next.out_y_max = res_hi[1];
        out_next.out_z_min = res_lo[2];
        out_next.out_z_max = res_hi[2];
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
        if (rdy2 && v1_reg)
        begin
            term_lo_reg <= term_lo_next;
            term_hi_reg <= term_hi_next;
        end
        if (rdy3 && v2_reg)
        begin
            sum_lo_reg <= sum_lo_next;
            sum_hi_reg <= sum_hi_next;
        end
        if (rdy4 && v3_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        term_order_ok = 1'b1;
        for (int a = 0; a < NumAxes; a++)
        begin
            for (int k = 0; k < NumAxes; k++)
            begin
                if (term_lo_reg[a][k] > term_hi_reg[a][k])
                begin
                    term_order_ok = 1'b0;
                end
            end
        end
    end

    assign out_order_ok = (out_data.out_x_min <= out_data.out_x_max)
                       && (out_data.out_y_min <= out_data.out_y_max)
                       && (out_data.out_z_min <= out_data.out_z_max);

    `AAT_ASSERT_SAME(a_out_ordered, clk, rst_n, out_valid, out_order_ok)
    `AAT_ASSERT_SAME(a_terms_ordered, clk, rst_n, v2_reg, term_order_ok)
    `AAT_ASSERT_NEXT(a_stage4_fill, clk, rst_n, v3_reg && rdy4, out_valid)
    `AAT_ASSERT_NEXT(a_stage1_fill, clk, rst_n, in_valid && in_ready, v1_reg)

endmodule
